FILE: hdl/rrjs_pkg.sv
package rrjs_pkg;

   localparam int ID_W       = 8;
   localparam int LEN_IN_W   = 16;
   localparam int SLICE_W    = 8;
   localparam int TIME_W     = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUANTUM_W  = 8;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic REG_MODE    = 1'b0;
   localparam logic REG_QUANTUM = 1'b1;

   localparam logic                 MODE_RESET    = 1'b1;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;
   localparam logic [SLICE_W-1:0]   SLICE_MAX     = 8'hFF;

   typedef struct packed {
      logic arrive;
      logic tick_start;
      logic dispatch;
      logic work;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

FILE: hdl/rrjs_ctrl.sv
module rrjs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_command,
   input  rrjs_pkg::dp_status_type status,
   output rrjs_pkg::ctrl_cmd_type  cmd
);
   import rrjs_pkg::*;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_DISPATCH = 2'd1;
   localparam logic [1:0] ST_WORK     = 2'd2;
   localparam logic [1:0] ST_EMIT     = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_command == CMD_TICK) begin
                  cmd.tick_start = 1'b1;
                  state_in       = ST_DISPATCH;
               end else begin
                  cmd.arrive = 1'b1;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_DISPATCH: begin
            cmd.dispatch = 1'b1;
            state_in     = ST_WORK;
         end
         ST_WORK: begin
            cmd.work = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/rrjs_dp.sv
module rrjs_dp #(
   parameter int QUEUE_DEPTH = 64,
   parameter int LENGTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrjs_pkg::ctrl_cmd_type            cmd,
   output rrjs_pkg::dp_status_type           status,
   input  logic                             rr_mode,
   input  logic [rrjs_pkg::QUANTUM_W-1:0]   quantum,
   input  logic [rrjs_pkg::ID_W-1:0]        job_id,
   input  logic [rrjs_pkg::LEN_IN_W-1:0]    job_length,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rrjs_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rrjs_pkg::*;

   localparam int LEN_W   = (LENGTH_BITS < LEN_IN_W) ? LENGTH_BITS : LEN_IN_W;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = ID_W + LEN_W;
   localparam int PAD_W   = RSP_DATA_W - (3 + 2 * ID_W + TIME_W);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [PTR_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic [ID_W-1:0]    cur_job_ff, cur_job_in;
   logic [LEN_W-1:0]   cur_rem_ff, cur_rem_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [TIME_W-1:0]  tick_ff, tick_in;
   logic               pop_ff, pop_in;
   logic               push_ff, push_in;

   logic               res_status_ff, res_status_in;
   logic               res_run_v_ff, res_run_v_in;
   logic [ID_W-1:0]    res_run_job_ff, res_run_job_in;
   logic               res_fin_v_ff, res_fin_v_in;
   logic [ID_W-1:0]    res_fin_job_ff, res_fin_job_in;
   logic [TIME_W-1:0]  res_fin_time_ff, res_fin_time_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic full;
   logic empty;
   logic preempt;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign preempt = rr_mode && busy_ff && (slice_ff >= quantum);

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      busy_in         = busy_ff;
      cur_job_in      = cur_job_ff;
      cur_rem_in      = cur_rem_ff;
      slice_in        = slice_ff;
      tick_in         = tick_ff;
      pop_in          = pop_ff;
      push_in         = push_ff;
      res_status_in   = res_status_ff;
      res_run_v_in    = res_run_v_ff;
      res_run_job_in  = res_run_job_ff;
      res_fin_v_in    = res_fin_v_ff;
      res_fin_job_in  = res_fin_job_ff;
      res_fin_time_in = res_fin_time_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      mem_we          = 1'b0;
      mem_waddr       = tail_ff;
      mem_wdata       = {job_id, job_length[LEN_W-1:0]};

      if (cmd.arrive) begin
         res_status_in   = full ? STATUS_FULL : STATUS_OK;
         res_run_v_in    = 1'b0;
         res_run_job_in  = '0;
         res_fin_v_in    = 1'b0;
         res_fin_job_in  = '0;
         res_fin_time_in = '0;
         if (!full) begin
            mem_we   = 1'b1;
            tail_in  = next_ptr(tail_ff);
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.tick_start) begin
         tick_in = tick_ff + TIME_W'(1);
         pop_in  = 1'b0;
         push_in = 1'b0;
         if (preempt && empty) begin
            slice_in = '0;
         end else if (preempt) begin
            pop_in  = 1'b1;
            push_in = 1'b1;
         end else if (!busy_ff && !empty) begin
            pop_in = 1'b1;
         end
      end

      if (cmd.dispatch) begin
         if (push_ff) begin
            mem_we    = 1'b1;
            mem_wdata = {cur_job_ff, cur_rem_ff};
            tail_in   = next_ptr(tail_ff);
         end
         if (pop_ff) begin
            cur_job_in = rd_data_ff[ENTRY_W-1:LEN_W];
            cur_rem_in = rd_data_ff[LEN_W-1:0];
            busy_in    = 1'b1;
            slice_in   = '0;
            head_in    = next_ptr(head_ff);
            if (!push_ff) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
      end

      if (cmd.work) begin
         res_status_in   = STATUS_OK;
         res_run_v_in    = busy_ff;
         res_run_job_in  = busy_ff ? cur_job_ff : '0;
         res_fin_v_in    = 1'b0;
         res_fin_job_in  = '0;
         res_fin_time_in = '0;
         if (busy_ff) begin
            if (slice_ff != SLICE_MAX) begin
               slice_in = slice_ff + SLICE_W'(1);
            end
            if (cur_rem_ff <= LEN_W'(1)) begin
               cur_rem_in      = '0;
               busy_in         = 1'b0;
               slice_in        = '0;
               res_fin_v_in    = 1'b1;
               res_fin_job_in  = cur_job_ff;
               res_fin_time_in = tick_ff + TIME_W'(1);
            end else begin
               cur_rem_in = cur_rem_ff - LEN_W'(1);
            end
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {PAD_W'(0), res_fin_time_ff, res_fin_job_ff, res_fin_v_ff,
                         res_run_job_ff, res_run_v_ff, res_status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.tick_start) begin
         rd_data_ff <= queue_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         cur_job_ff   <= '0;
         cur_rem_ff   <= '0;
         slice_ff     <= '0;
         tick_ff      <= '0;
         pop_ff       <= 1'b0;
         push_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         cur_job_ff   <= cur_job_in;
         cur_rem_ff   <= cur_rem_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         pop_ff       <= pop_in;
         push_ff      <= push_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff   <= res_status_in;
      res_run_v_ff    <= res_run_v_in;
      res_run_job_ff  <= res_run_job_in;
      res_fin_v_ff    <= res_fin_v_in;
      res_fin_job_ff  <= res_fin_job_in;
      res_fin_time_ff <= res_fin_time_in;
      rsp_data_ff     <= rsp_data_in;
   end

endmodule

FILE: hdl/round_robin_job_scheduler.sv
// Channel  Direction  Ports                         Carries
// req      in         req_tvalid/tready/tdata/tuser one arrive or tick command
// rsp      out        rsp_tvalid/tready/tdata       one result word per command
// csr      in/out     csr_psel..csr_pready          mode and quantum registers
//
// An arrive goes from idle to emit, a tick through dispatch and work to emit: the
// ready-queue memory has a registered read port, so the head is fetched, then dispatched, then worked on.
// The result sits in an output register; the next command is accepted while it
// waits, and the block holds in its last step only while the register is full and rsp_tready is low.
// Reset is synchronous; ready-queue contents are undefined until written.
module round_robin_job_scheduler #(
   parameter int QUEUE_DEPTH = 64,
   parameter int LENGTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // job_id [7:0], job_length [23:8]
   input  logic [rrjs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command [0]
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [0], running_valid [1], running_job [9:2], finish_valid [10],
   // finish_job [18:11], finish_time [50:19], zero [55:51]
   output logic [rrjs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rrjs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rrjs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rrjs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rrjs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic                 mode_ff, mode_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in    = mode_ff;
      quantum_in = quantum_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_MODE:    mode_in    = csr_pwdata[0];
            REG_QUANTUM: quantum_in = csr_pwdata[QUANTUM_W-1:0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MODE:    csr_prdata = {(CSR_DATA_W - 1)'(0), mode_ff};
         REG_QUANTUM: csr_prdata = {(CSR_DATA_W - QUANTUM_W)'(0), quantum_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         quantum_ff <= QUANTUM_RESET;
      end else begin
         mode_ff    <= mode_in;
         quantum_ff <= quantum_in;
      end
   end

   rrjs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser[0]),
      .status      (status),
      .cmd         (cmd)
   );

   rrjs_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rr_mode    (mode_ff),
      .quantum    (quantum_ff),
      .job_id     (req_tdata[ID_W-1:0]),
      .job_length (req_tdata[ID_W+LEN_IN_W-1:ID_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hdl/rrjs_checker.sv
module rrjs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rrjs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rrjs_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // drop all job fields when nothing ran
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[50:2] == '0)
      else $error("job fields set without a running job");

   a_finish_is_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[1] && (rsp_tdata[18:11] == rsp_tdata[9:2]))
      else $error("finished job differs from running job");

   a_full_arrive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[50:1] == '0)
      else $error("dropped arrival carries tick fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

endmodule

bind round_robin_job_scheduler rrjs_checker u_rrjs_checker (.*);

FILE: verif/tb_round_robin_job_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_job_scheduler;
   import rrjs_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam int SETTLE       = 8;
   localparam int TAIL_CYCLES  = 20;
   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_LIMIT  = 3000;

   typedef enum logic [1:0] {OP_WORD, OP_WRITE, OP_DRAIN, OP_HOLD} op_kind_type;

   typedef struct {
      op_kind_type      kind;
      logic             cmd;
      logic [7:0]       id;
      logic [15:0]      len;
      logic             idx;
      logic [31:0]      value;
      int               gap;
   } sched_op_type;

   // pad, finish_time, finish_job, finish_valid, running_job, running_valid, status
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] ftime;
      logic [7:0]  fjob;
      logic        fvalid;
      logic [7:0]  rjob;
      logic        rvalid;
      logic        status;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // job_id [7:0], job_length [23:8]
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // command [0]
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status [0], running_valid [1], running_job [9:2], finish_valid [10],
   // finish_job [18:11], finish_time [50:19], zero [55:51]
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   sched_op_type  pending_ops[$];
   outcome_type   expected_results[$];
   int         mismatch_count = 0;
   int         rsp_count = 0;
   logic [7:0] hold_token = '0;

   logic [7:0]         wait_id[QUEUE_DEPTH];
   logic [15:0]        wait_rem[QUEUE_DEPTH];
   logic [PTR_W-1:0]   wait_head = '0;
   logic [PTR_W-1:0]   wait_tail = '0;
   int unsigned        wait_count = 0;
   logic               run_busy = 1'b0;
   logic [7:0]         run_job = '0;
   logic [15:0]        run_left = '0;
   logic [SLICE_W-1:0] run_slice = '0;
   logic [31:0]        tick_total = '0;
   logic               cfg_mode = MODE_RESET;
   logic [7:0]         cfg_quantum = QUANTUM_RESET;

   round_robin_job_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .LENGTH_BITS(16)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void enqueue_job(logic [7:0] id, logic [15:0] rem);
      wait_id[wait_tail] = id;
      wait_rem[wait_tail] = rem;
      wait_tail = (wait_tail == LAST_SLOT) ? '0 : wait_tail + PTR_W'(1);
      wait_count++;
   endfunction

   function automatic outcome_type schedule_step(logic cmd, logic [7:0] id, logic [15:0] len);
      outcome_type o;
      logic       parked;
      logic [7:0] park_id;
      logic [15:0] park_rem;
      o = '0;
      parked = 1'b0;
      park_id = '0;
      park_rem = '0;
      if (cmd == CMD_ARRIVE) begin
         if (wait_count >= QUEUE_DEPTH) o.status = STATUS_FULL;
         else enqueue_job(id, len);
         return o;
      end
      tick_total = tick_total + 32'd1;
      if (cfg_mode == 1'b1 && run_busy && run_slice >= cfg_quantum) begin
         run_busy = 1'b0;
         run_slice = '0;
         if (wait_count < QUEUE_DEPTH) enqueue_job(run_job, run_left);
         else begin
            parked = 1'b1;
            park_id = run_job;
            park_rem = run_left;
         end
      end
      if (!run_busy && wait_count > 0) begin
         run_job = wait_id[wait_head];
         run_left = wait_rem[wait_head];
         wait_head = (wait_head == LAST_SLOT) ? '0 : wait_head + PTR_W'(1);
         wait_count--;
         run_busy = 1'b1;
         run_slice = '0;
      end
      if (parked) enqueue_job(park_id, park_rem);
      if (run_busy) begin
         o.rvalid = 1'b1;
         o.rjob = run_job;
         if (run_slice != SLICE_MAX) run_slice = run_slice + SLICE_W'(1);
         if (run_left <= 16'd1) begin
            run_left = '0;
            run_busy = 1'b0;
            run_slice = '0;
            o.fvalid = 1'b1;
            o.fjob = run_job;
            o.ftime = tick_total + 32'd1;
         end else begin
            run_left = run_left - 16'd1;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t rsp word %0d %s: got %0h, expected %0h", $time, rsp_count, field,
               got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : driver
      sched_op_type op;
      logic      nxt_valid;
      logic      nxt_psel;
      logic      nxt_penable;
      int        gap_count;
      int        settle_count;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         gap_count = 0;
         settle_count = 0;
      end else begin
         nxt_valid = req_tvalid;
         nxt_psel = csr_psel;
         nxt_penable = csr_penable;
         if (req_tvalid && req_tready) begin
            expected_results = {expected_results,
                                schedule_step(req_tuser[0], req_tdata[7:0],
                                              req_tdata[23:8])};
            nxt_valid = 1'b0;
         end
         if (csr_psel && !csr_penable) begin
            nxt_penable = 1'b1;
         end else if (csr_psel && csr_penable && csr_pready) begin
            if (csr_paddr[2] == REG_QUANTUM) cfg_quantum = csr_pwdata[7:0];
            else cfg_mode = csr_pwdata[0];
            nxt_psel = 1'b0;
            nxt_penable = 1'b0;
         end
         if (!nxt_valid && !nxt_psel && pending_ops.size() > 0) begin
            op = pending_ops[0];
            if (gap_count < op.gap) begin
               gap_count++;
            end else begin
               case (op.kind)
                  OP_WORD: begin
                     req_tuser <= op.cmd;
                     req_tdata <= {op.len, op.id};
                     nxt_valid = 1'b1;
                     pending_ops.delete(0);
                     gap_count = 0;
                  end
                  OP_WRITE: begin
                     csr_paddr <= {op.idx, 2'b00};
                     csr_pwdata <= op.value;
                     csr_pwrite <= 1'b1;
                     nxt_psel = 1'b1;
                     pending_ops.delete(0);
                  end
                  OP_DRAIN: begin
                     if (expected_results.size() != 0) begin
                        settle_count = 0;
                     end else if (settle_count < SETTLE) begin
                        settle_count++;
                     end else begin
                        settle_count = 0;
                        pending_ops.delete(0);
                     end
                  end
                  default: begin
                     hold_token <= hold_token + 8'd1;
                     pending_ops.delete(0);
                  end
               endcase
            end
         end
         req_tvalid <= nxt_valid;
         csr_psel <= nxt_psel;
         csr_penable <= nxt_penable;
      end
   end

   always @(posedge clock) begin : monitor
      outcome_type got;
      outcome_type want;
      logic       nxt_ready;
      logic [7:0] hold_seen;
      int         stall_left;
      int         free_left;
      int         r;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen = '0;
         stall_left = 0;
         free_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", 64'(got), '0);
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.rvalid !== want.rvalid)
                  report_mismatch("running_valid", 64'(got.rvalid), 64'(want.rvalid));
               if (got.rjob !== want.rjob)
                  report_mismatch("running_job", 64'(got.rjob), 64'(want.rjob));
               if (got.fvalid !== want.fvalid)
                  report_mismatch("finish_valid", 64'(got.fvalid), 64'(want.fvalid));
               if (got.fjob !== want.fjob)
                  report_mismatch("finish_job", 64'(got.fjob), 64'(want.fjob));
               if (got.ftime !== want.ftime)
                  report_mismatch("finish_time", 64'(got.ftime), 64'(want.ftime));
               if (got.pad !== want.pad)
                  report_mismatch("padding", 64'(got.pad), 64'(want.pad));
            end
            rsp_count++;
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            stall_left = HOLD_CYCLES;
            free_left = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
         end else if (free_left > 0) begin
            free_left--;
            nxt_ready = 1'b1;
         end else begin
            r = $urandom_range(0, 199);
            nxt_ready = 1'b0;
            if (r < 2) begin
               free_left = $urandom_range(30, 120);
               nxt_ready = 1'b1;
            end else if (r < 140) begin
               nxt_ready = 1'b1;
            end else if (r < 194) begin
               stall_left = $urandom_range(0, 2);
            end else begin
               stall_left = $urandom_range(15, 60);
            end
         end
         rsp_tready <= nxt_ready;
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset) begin
         quiet = 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 16'd0;
      if (r < 85) return 16'($urandom_range(1, 6));
      if (r < 97) return 16'($urandom_range(7, 30));
      return 16'($urandom_range(31, 120));
   endfunction

   task automatic add_word(logic cmd, logic [7:0] id, logic [15:0] len, int gap);
      sched_op_type op;
      op = '{kind: OP_WORD, cmd: cmd, id: id, len: len, idx: REG_MODE, value: '0, gap: gap};
      pending_ops = {pending_ops, op};
   endtask

   task automatic add_control(op_kind_type kind, logic idx, logic [31:0] value);
      sched_op_type op;
      op = '{kind: kind, cmd: CMD_TICK, id: '0, len: '0, idx: idx, value: value, gap: 0};
      pending_ops = {pending_ops, op};
   endtask

   task automatic set_registers(logic mode, logic [7:0] quantum);
      add_control(OP_DRAIN, REG_MODE, '0);
      add_control(OP_WRITE, REG_MODE, {31'd0, mode});
      add_control(OP_WRITE, REG_QUANTUM, {24'd0, quantum});
   endtask

   task automatic add_random_phase(int n_items, bit gapless);
      int left;
      int burst;
      int k;
      bit ticking;
      left = n_items;
      while (left > 0) begin
         ticking = ($urandom_range(0, 99) < 55);
         burst = ticking ? $urandom_range(1, 16) : $urandom_range(1, 5);
         for (k = 0; k < burst && left > 0; k++) begin
            if (ticking)
               add_word(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        gapless ? 0 : pick_gap());
            else
               add_word(CMD_ARRIVE, 8'($urandom_range(0, 255)), pick_length(),
                        gapless ? 0 : pick_gap());
            left--;
         end
      end
   endtask

   initial begin : stimulus
      int k;
      add_word(CMD_ARRIVE, 8'h00, 16'd1, pick_gap());
      add_word(CMD_ARRIVE, 8'hA5, 16'd0, pick_gap());
      add_word(CMD_ARRIVE, 8'h5A, 16'd6, pick_gap());
      add_word(CMD_ARRIVE, 8'hC3, 16'd2, pick_gap());
      for (k = 0; k < 12; k++) add_word(CMD_TICK, 8'hFF, 16'hFFFF, pick_gap());
      add_word(CMD_ARRIVE, 8'hFF, 16'd3, pick_gap());
      for (k = 0; k < 4; k++) add_word(CMD_TICK, 8'h00, 16'h0000, pick_gap());

      set_registers(1'b0, 8'd255);
      add_random_phase(150, 1'b0);
      set_registers(1'b1, 8'd1);
      add_random_phase(150, 1'b1);
      set_registers(1'b1, 8'd0);
      add_random_phase(100, 1'b0);

      // fill the ready queue, then preempt into it while full
      set_registers(1'b1, 8'd3);
      for (k = 0; k < 72; k++)
         add_word(CMD_ARRIVE, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 6)), 0);
      for (k = 0; k < 20; k++) begin
         add_word(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 0);
         add_word(CMD_ARRIVE, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 6)), 0);
      end
      add_control(OP_HOLD, REG_MODE, '0);
      add_random_phase(40, 1'b1);

      set_registers(1'b0, 8'($urandom_range(1, 255)));
      add_random_phase(120, 1'b0);
      set_registers(1'b1, 8'd2);
      add_random_phase(100, 1'b0);
      set_registers(1'b1, 8'd8);
      add_random_phase(120, 1'b0);

      add_word(CMD_ARRIVE, 8'hFF, 16'hFFFF, pick_gap());
      for (k = 0; k < 3; k++) add_word(CMD_TICK, 8'h00, 16'h0000, pick_gap());

      while (pending_ops.size() != 0 || req_tvalid || csr_psel ||
             expected_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
